@@ hw/rtl/plm_pkg.sv @@
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types, codes and helper functions of the posting list merge block.
// ----------------------------------------------------------------------------
`default_nettype none
package plm_pkg;

  localparam int ID_W  = 32;
  localparam int SC_W  = 32;
  localparam int CMD_W = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int BANK_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD        = 2'd0,
    CMD_CLOSE_RANGE = 2'd1,
    CMD_CLOSE_GROUP = 2'd2,
    CMD_FINISH      = 2'd3
  } cmd_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FILTER_ENABLE = 2'd0,
    CFG_SCORE_FLOOR   = 2'd1,
    CFG_SCORE_CEILING = 2'd2
  } cfg_index_e;

  typedef logic [BANK_W-1:0] bank_t;

  // Bank 0 always holds the open range list; banks 1 to 3 are shared by
  // the key group, the answer and the output of a merge in progress.
  localparam bank_t RANGE_BANK = 2'd0;
  localparam bank_t BANK_ONE   = 2'd1;
  localparam bank_t BANK_TWO   = 2'd2;
  localparam bank_t BANK_THREE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SC_W-1:0] sc;
  } entry_t;

  typedef struct packed {
    logic            id_eq;
    logic            id_lt;
    logic            a_first;
    logic [SC_W-1:0] sum;
  } alu_res_t;

  // True when entry a ranks ahead of entry b: higher score, then lower id.
  function automatic logic ranks_before(entry_t a, entry_t b);
    if (a.sc != b.sc) return a.sc > b.sc;
    return a.id < b.id;
  endfunction

  // A list bank that is neither of the two banks in use.
  function automatic bank_t free_bank(bank_t g, bank_t a);
    if (g != BANK_ONE && a != BANK_ONE) return BANK_ONE;
    if (g != BANK_TWO && a != BANK_TWO) return BANK_TWO;
    return BANK_THREE;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/plm_if.sv @@
// ----------------------------------------------------------------------------
// plm_in_if / plm_out_if
// Valid/ready channels carrying posting commands in and ranked results out.
// ----------------------------------------------------------------------------
`default_nettype none
interface plm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] doc_id;
  logic [31:0] score;

  modport source (output valid, output command, output doc_id, output score,
                  input ready);
  modport sink   (input valid, input command, input doc_id, input score,
                  output ready);
endinterface

interface plm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_id;
  logic [31:0] result_score;
  logic        valid_res;
  logic        overflow;
  logic        last;

  modport source (output valid, output result_id, output result_score,
                  output valid_res, output overflow, output last, input ready);
  modport sink   (input valid, input result_id, input result_score,
                  input valid_res, input overflow, input last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/posting_list_merge_rank_core.sv @@
// ----------------------------------------------------------------------------
// posting_list_merge_rank_core
// Builds sorted posting lists, unions range lists into key groups,
// intersects key groups into the answer and emits the answer ranked.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat payload                                    handshake
//  req      in   command, doc_id, score                          valid/ready
//  rsp      out  result_id, result_score, valid_res, overflow,   valid/ready
//               last
//  cfg      in   cfg_index, cfg_data                             cfg_we only
//
// One command is taken at a time; req.ready is high only while the sequencer
// is idle. A load scans the open range list from its top and then shifts
// the entries above the insert point; a load of an id already listed adds
// its score in place. A close walks both lists through the shared compare
// unit. A finish runs one selection scan over the answer per emitted beat.
// Reset (rst, synchronous) empties all lists at once through their counts.
// A stalled rsp only holds the sequencer when a new beat is ready to go.
//
// All three lists live in one memory with two registered read ports; the
// open range list keeps a fixed bank while the key group and the answer
// rename among three banks, so no list is ever copied.
// ----------------------------------------------------------------------------
`default_nettype none
module posting_list_merge_rank_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [plm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [plm_pkg::CFG_DATA_W-1:0]      cfg_data,
  plm_in_if.sink                                   req,
  plm_out_if.source                                rsp
);
  import plm_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_LD_RD    = 13'b0000000000010,
    S_LD_CMP   = 13'b0000000000100,
    S_LD_CHK   = 13'b0000000001000,
    S_LD_SH_RD = 13'b0000000010000,
    S_LD_SH_WR = 13'b0000000100000,
    S_LD_INS   = 13'b0000001000000,
    S_MG_RD    = 13'b0000010000000,
    S_MG_CMP   = 13'b0000100000000,
    S_MG_NEXT  = 13'b0001000000000,
    S_SC_RD    = 13'b0010000000000,
    S_SC_CMP   = 13'b0100000000000,
    S_SC_END   = 13'b1000000000000
  } state_e;

  state_e state;

  // Configuration registers.
  logic            filter_enable;
  logic [SC_W-1:0] score_floor;
  logic [SC_W-1:0] score_ceiling;

  // Query state.
  logic [CW-1:0] rcount;
  logic [CW-1:0] gcount;
  logic [CW-1:0] acount;
  logic          first_pending;
  logic          overflow_flag;
  bank_t         group_bank;
  bank_t         answer_bank;

  // Load sequencer.
  entry_t        new_entry;
  logic [IW-1:0] lk;
  logic [CW-1:0] pos;

  // Merge sequencer.
  logic          mg_union;
  logic          mg_group;
  bank_t         ba;
  bank_t         bb;
  bank_t         bo;
  logic [CW-1:0] na;
  logic [CW-1:0] nb;
  logic [CW-1:0] mi;
  logic [CW-1:0] mj;
  logic [CW-1:0] mt;

  // Ranking scan.
  logic [CW-1:0] si;
  entry_t        best;
  logic          have_best;
  entry_t        cur;
  logic          have_cur;

  // Output register.
  logic            o_valid;
  logic [ID_W-1:0] o_id;
  logic [SC_W-1:0] o_sc;
  logic            o_valid_res;
  logic            o_overflow;
  logic            o_last;
  logic            out_free;
  logic            emit;

  // Memory and shared unit.
  logic                  mem_we;
  logic [BANK_W+IW-1:0]  mem_waddr;
  entry_t                mem_wdata;
  logic [BANK_W+IW-1:0]  raddr_a;
  logic [BANK_W+IW-1:0]  raddr_b;
  entry_t                rdata_a;
  entry_t                rdata_b;
  entry_t                alu_b;
  alu_res_t              alu;

  // Merge step decode.
  logic   av;
  logic   bv;
  logic   mg_done;
  logic   adv_a;
  logic   adv_b;
  logic   push;
  entry_t push_entry;
  logic   cand_ok;

  plm_store #(.IW(IW)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  plm_alu u_alu (
    .a   (rdata_a),
    .b   (alu_b),
    .res (alu)
  );

  assign req.ready = (state == S_IDLE);
  assign out_free  = !o_valid || rsp.ready;

  // A result beat is loaded into the output register when the ranking
  // sequencer has a beat to send and the register is free.
  assign emit = (state == S_SC_END) && (have_cur || !have_best) && out_free;

  assign rsp.valid        = o_valid;
  assign rsp.result_id    = o_id;
  assign rsp.result_score = o_sc;
  assign rsp.valid_res    = o_valid_res;
  assign rsp.overflow     = o_overflow;
  assign rsp.last         = o_last;

  // The shared unit compares the word just read against the new entry on a
  // load, against the best candidate so far on a scan, and against the other
  // read port on a merge.
  always_comb begin
    unique case (state)
      S_LD_CMP: alu_b = new_entry;
      S_SC_CMP: alu_b = best;
      default:  alu_b = rdata_b;
    endcase
  end

  // One step of a union or an intersection of two id-sorted lists.
  always_comb begin
    av = (mi < na);
    bv = (mj < nb);
    if (mg_union) begin
      mg_done    = !av && !bv;
      adv_a      = av && (!bv || alu.id_eq || alu.id_lt);
      adv_b      = bv && (!av || alu.id_eq || !alu.id_lt);
      push       = !mg_done;
      if (av && bv && alu.id_eq) begin
        push_entry = '{id: rdata_a.id, sc: alu.sum};
      end else if (adv_a) begin
        push_entry = rdata_a;
      end else begin
        push_entry = rdata_b;
      end
    end else begin
      mg_done    = !av || !bv;
      adv_a      = !mg_done && (alu.id_eq || alu.id_lt);
      adv_b      = !mg_done && !alu.id_lt;
      push       = !mg_done && alu.id_eq;
      push_entry = '{id: rdata_a.id, sc: alu.sum};
    end
  end

  // A scanned answer entry is a candidate when it passes the score window,
  // ranks after the beat already chosen and ahead of the best one so far.
  always_comb begin
    cand_ok = (!filter_enable ||
               (rdata_a.sc >= score_floor && rdata_a.sc < score_ceiling)) &&
              (!have_cur || ranks_before(cur, rdata_a)) &&
              (!have_best || alu.a_first);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {RANGE_BANK, lk};
    mem_wdata = new_entry;
    raddr_a   = {RANGE_BANK, lk};
    raddr_b   = {bb, mj[IW-1:0]};
    unique case (state)
      S_LD_CMP: begin
        mem_we    = alu.id_eq;
        mem_wdata = '{id: new_entry.id, sc: alu.sum};
      end
      S_LD_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {RANGE_BANK, IW'(lk + 1'b1)};
        mem_wdata = rdata_a;
      end
      S_LD_INS: begin
        mem_we    = 1'b1;
        mem_waddr = {RANGE_BANK, pos[IW-1:0]};
      end
      S_MG_RD: begin
        raddr_a = {ba, mi[IW-1:0]};
      end
      S_MG_CMP: begin
        mem_we    = push && (mt < MAX_CNT);
        mem_waddr = {bo, mt[IW-1:0]};
        mem_wdata = push_entry;
      end
      S_SC_RD: begin
        raddr_a = {answer_bank, si[IW-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      score_floor   <= '0;
      score_ceiling <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ENABLE: filter_enable <= cfg_data[0];
        CFG_SCORE_FLOOR:   score_floor   <= cfg_data;
        CFG_SCORE_CEILING: score_ceiling <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rcount        <= '0;
      gcount        <= '0;
      acount        <= '0;
      first_pending <= 1'b1;
      overflow_flag <= 1'b0;
      group_bank    <= BANK_ONE;
      answer_bank   <= BANK_TWO;
      o_valid       <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            new_entry <= '{id: req.doc_id, sc: req.score};
            unique case (cmd_e'(req.command))
              CMD_LOAD: begin
                if (rcount == '0) begin
                  pos   <= '0;
                  state <= S_LD_CHK;
                end else begin
                  lk    <= IW'(rcount - 1'b1);
                  state <= S_LD_RD;
                end
              end
              CMD_CLOSE_RANGE, CMD_CLOSE_GROUP: begin
                mg_union <= 1'b1;
                mg_group <= (cmd_e'(req.command) == CMD_CLOSE_GROUP);
                ba       <= RANGE_BANK;
                na       <= rcount;
                bb       <= group_bank;
                nb       <= gcount;
                bo       <= free_bank(group_bank, answer_bank);
                mi       <= '0;
                mj       <= '0;
                mt       <= '0;
                state    <= S_MG_RD;
              end
              CMD_FINISH: begin
                have_cur  <= 1'b0;
                have_best <= 1'b0;
                si        <= '0;
                state     <= (acount == '0) ? S_SC_END : S_SC_RD;
              end
              default: begin
              end
            endcase
          end
        end

        // Find the insert point, walking down from the top entry.
        S_LD_RD: state <= S_LD_CMP;
        S_LD_CMP: begin
          if (alu.id_eq) begin
            state <= S_IDLE;
          end else if (alu.id_lt) begin
            pos   <= CW'(lk) + 1'b1;
            state <= S_LD_CHK;
          end else if (lk == '0) begin
            pos   <= '0;
            state <= S_LD_CHK;
          end else begin
            lk    <= lk - 1'b1;
            state <= S_LD_RD;
          end
        end
        S_LD_CHK: begin
          if (rcount == MAX_CNT) begin
            overflow_flag <= 1'b1;
            state         <= S_IDLE;
          end else if (pos == rcount) begin
            state <= S_LD_INS;
          end else begin
            lk    <= IW'(rcount - 1'b1);
            state <= S_LD_SH_RD;
          end
        end
        S_LD_SH_RD: state <= S_LD_SH_WR;
        S_LD_SH_WR: begin
          if (CW'(lk) == pos) begin
            state <= S_LD_INS;
          end else begin
            lk    <= lk - 1'b1;
            state <= S_LD_SH_RD;
          end
        end
        S_LD_INS: begin
          rcount <= rcount + 1'b1;
          state  <= S_IDLE;
        end

        S_MG_RD: state <= S_MG_CMP;
        S_MG_CMP: begin
          if (mg_done) begin
            if (mg_union) begin
              group_bank <= bo;
              gcount     <= mt;
              rcount     <= '0;
              state      <= mg_group ? S_MG_NEXT : S_IDLE;
            end else begin
              answer_bank <= bo;
              acount      <= mt;
              gcount      <= '0;
              state       <= S_IDLE;
            end
          end else begin
            if (push) begin
              if (mt < MAX_CNT) begin
                mt <= mt + 1'b1;
              end else begin
                overflow_flag <= 1'b1;
              end
            end
            if (adv_a) mi <= mi + 1'b1;
            if (adv_b) mj <= mj + 1'b1;
            state <= S_MG_RD;
          end
        end
        // The first closed group becomes the answer by renaming its bank;
        // later groups are intersected with the answer.
        S_MG_NEXT: begin
          if (first_pending) begin
            answer_bank   <= group_bank;
            acount        <= gcount;
            group_bank    <= free_bank(group_bank, answer_bank);
            gcount        <= '0;
            first_pending <= 1'b0;
            state         <= S_IDLE;
          end else begin
            mg_union <= 1'b0;
            ba       <= group_bank;
            na       <= gcount;
            bb       <= answer_bank;
            nb       <= acount;
            bo       <= free_bank(group_bank, answer_bank);
            mi       <= '0;
            mj       <= '0;
            mt       <= '0;
            state    <= S_MG_RD;
          end
        end

        // Selection scan: each pass finds the next entry in rank order.
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          if (cand_ok) begin
            best      <= rdata_a;
            have_best <= 1'b1;
          end
          if (CW'(si + 1'b1) == acount) begin
            state <= S_SC_END;
          end else begin
            si    <= si + 1'b1;
            state <= S_SC_RD;
          end
        end
        // Emit the entry found by the previous pass, now that it is known
        // whether another one follows it.
        S_SC_END: begin
          if (!have_cur && have_best) begin
            cur       <= best;
            have_cur  <= 1'b1;
            have_best <= 1'b0;
            si        <= '0;
            state     <= S_SC_RD;
          end else if (out_free) begin
            o_id        <= have_cur ? cur.id : '0;
            o_sc        <= have_cur ? cur.sc : '0;
            o_valid_res <= have_cur;
            o_overflow  <= overflow_flag;
            o_last      <= !have_best;
            if (have_best) begin
              cur       <= best;
              have_best <= 1'b0;
              si        <= '0;
              state     <= S_SC_RD;
            end else begin
              rcount        <= '0;
              gcount        <= '0;
              acount        <= '0;
              first_pending <= 1'b1;
              overflow_flag <= 1'b0;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_banks_apart: assert property (@(posedge clk) disable iff (rst)
    group_bank != answer_bank && group_bank != RANGE_BANK &&
    answer_bank != RANGE_BANK)
    else $error("key group and answer share a bank");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    rcount <= MAX_CNT && gcount <= MAX_CNT && acount <= MAX_CNT)
    else $error("list count beyond capacity");

  a_scan_read_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_RD || state == S_SC_CMP || state == S_SC_END) |-> !mem_we)
    else $error("list memory written during ranking");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.command == CMD_LOAD) |=> !req.ready)
    else $error("load finished without a sequencer step");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/plm_store.sv @@
// ----------------------------------------------------------------------------
// plm_store
// List memory: four banks of entries, one write port, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none
module plm_store #(
  parameter int IW = 6
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [plm_pkg::BANK_W+IW-1:0]   waddr,
  input  wire plm_pkg::entry_t                 wdata,
  input  wire logic [plm_pkg::BANK_W+IW-1:0]   raddr_a,
  input  wire logic [plm_pkg::BANK_W+IW-1:0]   raddr_b,
  output plm_pkg::entry_t                      rdata_a,
  output plm_pkg::entry_t                      rdata_b
);
  import plm_pkg::*;

  localparam int DEPTH = 1 << (BANK_W + IW);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ hw/rtl/plm_alu.sv @@
// ----------------------------------------------------------------------------
// plm_alu
// Shared compare and saturating add unit for two list entries.
// ----------------------------------------------------------------------------
`default_nettype none
module plm_alu (
  input  wire plm_pkg::entry_t a,
  input  wire plm_pkg::entry_t b,
  output plm_pkg::alu_res_t    res
);
  import plm_pkg::*;

  logic [SC_W:0] wide_sum;

  assign wide_sum    = {1'b0, a.sc} + {1'b0, b.sc};
  assign res.sum     = wide_sum[SC_W] ? {SC_W{1'b1}} : wide_sum[SC_W-1:0];
  assign res.id_eq   = (a.id == b.id);
  assign res.id_lt   = (a.id < b.id);
  assign res.a_first = ranks_before(a, b);

endmodule
`default_nettype wire
